// File: hdl/dcr_pkg.sv
package dcr_pkg;

   typedef logic [7:0]  cmd_type;
   typedef logic [7:0]  pixel_type;
   typedef logic [7:0]  coord_in_type;

   // Opcodes in bits 7..6 of a command word.
   localparam logic [1:0] OPC_DX   = 2'd0;
   localparam logic [1:0] OPC_DY   = 2'd1;
   localparam logic [1:0] OPC_TOOL = 2'd2;
   localparam logic [1:0] OPC_DATA = 2'd3;

   // Tool selection held in the tool register.
   localparam logic [1:0] TOOL_NONE  = 2'd0;
   localparam logic [1:0] TOOL_LINE  = 2'd1;
   localparam logic [1:0] TOOL_BLOCK = 2'd2;

   // Operand codes of a tool operation.
   localparam logic [5:0] TOP_SEL_NONE  = 6'd0;
   localparam logic [5:0] TOP_SEL_LINE  = 6'd1;
   localparam logic [5:0] TOP_SEL_BLOCK = 6'd2;
   localparam logic [5:0] TOP_COLOUR    = 6'd3;
   localparam logic [5:0] TOP_TARGET_X  = 6'd4;
   localparam logic [5:0] TOP_TARGET_Y  = 6'd5;

   // Grey conversion: (299R + 587G + 114B + 500) / 1000, the division done as
   // a multiplication by ceil(2^28 / 1000), which is exact for sums below 2^18.
   localparam int unsigned SUM_W      = 18;
   localparam int unsigned RECIP_W    = 19;
   localparam logic [9:0]  GREY_K_R   = 10'd299;
   localparam logic [9:0]  GREY_K_G   = 10'd587;
   localparam logic [9:0]  GREY_K_B   = 10'd114;
   localparam logic [9:0]  GREY_BIAS  = 10'd500;
   localparam logic [RECIP_W-1:0] GREY_RECIP = 19'd268436;
   localparam int unsigned GREY_SHIFT = 28;
   localparam logic [7:0]  GREY_RESET = 8'hFF;

endpackage

// File: hdl/dcr_if.sv
interface dcr_req_if;
   logic                 valid;
   logic                 ready;
   logic                 action;
   dcr_pkg::cmd_type      command;
   dcr_pkg::coord_in_type read_x;
   dcr_pkg::coord_in_type read_y;

   modport source (output valid, output action, output command, output read_x,
                   output read_y, input ready);
   modport sink   (input valid, input action, input command, input read_x,
                   input read_y, output ready);
endinterface

interface dcr_rsp_if;
   logic               valid;
   logic               ready;
   dcr_pkg::pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

// File: hdl/drawing_command_rasterizer.sv
// Drawing command rasterizer with an 8-bit greyscale canvas held in one
// synchronous memory of CANVAS_WIDTH x CANVAS_HEIGHT bytes.
// The request channel carries either a command word (action 0) or a pixel
// read (action 1, at read_x, read_y). Only a read gives a response word, which
// carries the grey value, or 0 for a position off the canvas.
// A command that does not draw is accepted, then executed;
// the colour operation adds a grey state, since the grey sum and the reciprocal
// multiplication sit in separate cycles. A drawing command then steps the
// sequencer through every pixel it visits in the draw state, because the single
// memory write port takes one pixel a cycle; on a line, pixels off the canvas
// are still stepped through, while a block is clipped first. A read gives its
// response through the memory read register, then the output register.
// After reset the sequencer clears the canvas, one entry a cycle, all
// CANVAS_WIDTH * CANVAS_HEIGHT entries (65536 by default), with ready low.
// The response sits in an output register; while the receiver stalls,
// commands are still accepted, and a further read waits in its read state
// until the register is free.
module drawing_command_rasterizer #(
   parameter int unsigned CANVAS_WIDTH  = 256,
   parameter int unsigned CANVAS_HEIGHT = 256
) (
   input  logic       clock,
   input  logic       reset,
   dcr_req_if.sink    req_chan,
   dcr_rsp_if.source  rsp_chan
);

   localparam int unsigned DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned X_W    = $clog2(CANVAS_WIDTH);
   localparam int unsigned Y_W    = $clog2(CANVAS_HEIGHT);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_DRAW  = 3'd3;
   localparam logic [2:0] ST_GREY  = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;

   localparam logic [15:0] WIDTH16  = 16'(CANVAS_WIDTH);
   localparam logic [15:0] HEIGHT16 = 16'(CANVAS_HEIGHT);

   logic [7:0] canvas_mem [DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;
   logic [15:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [1:0]  tool_ff, tool_in;
   logic [31:0] colour_ff, colour_in;
   logic [7:0]  grey_ff, grey_in;
   logic [dcr_pkg::SUM_W-1:0] sum_ff, sum_in;
   // The row of a diagonal can run past the 16-bit range, so it is kept wider.
   logic [15:0] cur_x_ff, cur_x_in;
   logic [17:0] cur_y_ff, cur_y_in;
   logic [15:0] step_x_ff, step_x_in;
   logic [17:0] step_y_ff, step_y_in;
   logic [16:0] cnt_ff, cnt_in;
   logic        blk_ff, blk_in;
   logic [15:0] row_start_ff, row_start_in, last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic        rd_off_ff, rd_off_in;
   logic [7:0]  rd_data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_pixel_ff, rsp_pixel_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              req_take;

   logic [15:0]        op16, ty_new;
   logic signed [16:0] ddx, ddy, adx, ady;
   logic signed [15:0] ex_s, ey_s, sx_s, sy_s;
   logic signed [15:0] bx0, by0, bx1, by1;
   logic [36:0]        grey_prod;

   function automatic logic in_canvas(input logic [15:0] x, input logic [17:0] y);
      in_canvas = !x[15] && (x < WIDTH16) && !y[17] && (y < 18'(HEIGHT16));
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(input logic [15:0] x,
                                                  input logic [15:0] y);
      pix_addr = ADDR_W'(ADDR_W'(y[Y_W-1:0]) * ADDR_W'(CANVAS_WIDTH))
                 + ADDR_W'(x[X_W-1:0]);
   endfunction

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pixel = rsp_pixel_ff;

   assign rd_en   = req_take && req_chan.action;
   assign rd_addr = pix_addr({8'd0, req_chan.read_x}, {8'd0, req_chan.read_y});

   // Command decode terms, all taken from registers: command word, pen, target, grey sum.
   assign op16   = {{10{cmd_ff[5]}}, cmd_ff[5:0]};
   assign ty_new = tgt_y_ff + op16;
   assign sx_s   = signed'(pen_x_ff);
   assign sy_s   = signed'(pen_y_ff);
   assign ex_s   = signed'(tgt_x_ff);
   assign ey_s   = signed'(ty_new);
   assign ddx    = 17'(ex_s) - 17'(sx_s);
   assign ddy    = 17'(ey_s) - 17'(sy_s);
   assign adx    = ddx[16] ? -ddx : ddx;
   assign ady    = ddy[16] ? -ddy : ddy;
   assign bx0    = sx_s[15] ? 16'sd0 : sx_s;
   assign by0    = sy_s[15] ? 16'sd0 : sy_s;
   assign bx1    = (ex_s > signed'(WIDTH16)) ? signed'(WIDTH16) : ex_s;
   assign by1    = (ey_s > signed'(HEIGHT16)) ? signed'(HEIGHT16) : ey_s;
   assign grey_prod = 37'(sum_ff) * 37'(dcr_pkg::GREY_RECIP);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      tool_in      = tool_ff;
      colour_in    = colour_ff;
      grey_in      = grey_ff;
      sum_in       = sum_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      cnt_in       = cnt_ff;
      blk_in       = blk_ff;
      row_start_in = row_start_ff;
      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      clr_in       = clr_ff;
      rd_off_in    = rd_off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_pixel_in = rsp_pixel_ff;
      mem_we       = 1'b0;
      mem_waddr    = pix_addr(cur_x_ff, cur_y_ff[15:0]);
      mem_wdata    = grey_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd_in    = req_chan.command;
               rd_off_in = ({8'd0, req_chan.read_x} >= WIDTH16)
                           || ({8'd0, req_chan.read_y} >= HEIGHT16);
               state_in  = req_chan.action ? ST_READ : ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cmd_ff[7:6])
               dcr_pkg::OPC_DX: begin
                  tgt_x_in = tgt_x_ff + op16;
                  if (tool_ff == dcr_pkg::TOOL_NONE) begin
                     pen_x_in = tgt_x_ff + op16;
                  end
               end
               dcr_pkg::OPC_DY: begin
                  tgt_y_in = ty_new;
                  if (tool_ff == dcr_pkg::TOOL_LINE) begin
                     pen_x_in = tgt_x_ff;
                     pen_y_in = ty_new;
                     blk_in   = 1'b0;
                     state_in = ST_DRAW;
                     if (ddx == 17'sd0) begin
                        cur_x_in  = pen_x_ff;
                        cur_y_in  = ddy[16] ? 18'(ey_s) : 18'(sy_s);
                        step_x_in = 16'd0;
                        step_y_in = 18'd1;
                        cnt_in    = 17'(ady) + 17'd1;
                     end else if (ddy == 17'sd0) begin
                        cur_x_in  = ddx[16] ? tgt_x_ff : pen_x_ff;
                        cur_y_in  = 18'(sy_s);
                        step_x_in = 16'd1;
                        step_y_in = 18'd0;
                        cnt_in    = 17'(adx) + 17'd1;
                     end else begin
                        // Diagonal: one pixel per column, endpoint left out.
                        cur_x_in  = pen_x_ff;
                        cur_y_in  = 18'(sy_s);
                        step_x_in = ddx[16] ? 16'hFFFF : 16'd1;
                        step_y_in = ddy[16] ? 18'h3FFFF : 18'd1;
                        cnt_in    = 17'(adx);
                     end
                  end else if (tool_ff == dcr_pkg::TOOL_BLOCK) begin
                     blk_in       = 1'b1;
                     cur_x_in     = bx0;
                     cur_y_in     = 18'(by0);
                     row_start_in = bx0;
                     last_x_in    = bx1 - 16'sd1;
                     last_y_in    = by1 - 16'sd1;
                     if ((bx0 < bx1) && (by0 < by1)) begin
                        state_in = ST_DRAW;
                     end
                  end else if (tool_ff == dcr_pkg::TOOL_NONE) begin
                     pen_y_in = ty_new;
                  end
               end
               dcr_pkg::OPC_TOOL: begin
                  colour_in = 32'd0;
                  unique case (cmd_ff[5:0])
                     dcr_pkg::TOP_SEL_NONE:  tool_in = dcr_pkg::TOOL_NONE;
                     dcr_pkg::TOP_SEL_LINE:  tool_in = dcr_pkg::TOOL_LINE;
                     dcr_pkg::TOP_SEL_BLOCK: begin
                        tool_in  = dcr_pkg::TOOL_BLOCK;
                        pen_x_in = tgt_x_ff;
                        pen_y_in = tgt_y_ff;
                     end
                     dcr_pkg::TOP_COLOUR: begin
                        sum_in = dcr_pkg::SUM_W'(
                                 dcr_pkg::SUM_W'(colour_ff[31:24]) * dcr_pkg::SUM_W'(dcr_pkg::GREY_K_R)
                               + dcr_pkg::SUM_W'(colour_ff[23:16]) * dcr_pkg::SUM_W'(dcr_pkg::GREY_K_G)
                               + dcr_pkg::SUM_W'(colour_ff[15:8]) * dcr_pkg::SUM_W'(dcr_pkg::GREY_K_B)
                               + dcr_pkg::SUM_W'(dcr_pkg::GREY_BIAS));
                        state_in = ST_GREY;
                     end
                     dcr_pkg::TOP_TARGET_X: tgt_x_in = colour_ff[15:0];
                     dcr_pkg::TOP_TARGET_Y: tgt_y_in = colour_ff[15:0];
                     default: ;
                  endcase
               end
               dcr_pkg::OPC_DATA: begin
                  colour_in = {colour_ff[25:0], cmd_ff[5:0]};
               end
               default: ;
            endcase
         end
         ST_DRAW: begin
            mem_we = in_canvas(cur_x_ff, cur_y_ff);
            if (blk_ff) begin
               if (cur_x_ff == last_x_ff) begin
                  cur_x_in = row_start_ff;
                  cur_y_in = cur_y_ff + 18'd1;
                  if (cur_y_ff[15:0] == last_y_ff) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  cur_x_in = cur_x_ff + 16'd1;
               end
            end else begin
               cur_x_in = cur_x_ff + step_x_ff;
               cur_y_in = cur_y_ff + step_y_ff;
               cnt_in   = cnt_ff - 17'd1;
               if (cnt_ff == 17'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_GREY: begin
            // The quotient never exceeds 255, so eight bits hold it whole.
            grey_in  = grey_prod[dcr_pkg::GREY_SHIFT +: 8];
            state_in = ST_IDLE;
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = rd_off_ff ? 8'd0 : rd_data_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= canvas_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pen_x_ff     <= 16'd0;
         pen_y_ff     <= 16'd0;
         tgt_x_ff     <= 16'd0;
         tgt_y_ff     <= 16'd0;
         tool_ff      <= dcr_pkg::TOOL_LINE;
         colour_ff    <= 32'd0;
         grey_ff      <= dcr_pkg::GREY_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 17'd0;
         blk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         tool_ff      <= tool_in;
         colour_ff    <= colour_in;
         grey_ff      <= grey_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         blk_ff       <= blk_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sum_ff       <= sum_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      step_x_ff    <= step_x_in;
      step_y_ff    <= step_y_in;
      row_start_ff <= row_start_in;
      last_x_ff    <= last_x_in;
      last_y_ff    <= last_y_in;
      rd_off_ff    <= rd_off_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // A new response word only ever follows the read state.
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_READ)
      else $error("response raised outside the read state");

   // The canvas is written only by the clearing pass or the draw sequencer.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_DRAW))
      else $error("canvas written outside clearing or drawing");

   // A line draw never runs with its pixel count spent.
   a_line_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW) && !blk_ff |-> cnt_ff != 17'd0)
      else $error("line sequencer running with zero count");

   // An accepted read always enters the read state, where it waits to respond.
   a_read_single: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> state_ff == ST_READ)
      else $error("read accepted without entering the read state");

endmodule
